@@ design/gpce_pkg.sv @@
// ----------------------------------------------------------------------------
// gpce_pkg: shared types and constants for the Gaussian density/area core
// Fixed-point formats, approximation coefficients, register codes and the
// signed-by-unsigned fixed-point multiply used by the polynomial and tail.
// ----------------------------------------------------------------------------
package gpce_pkg;

  // Fraction bits of x, mean, inv_deviation, peak_height and density
  localparam int unsigned FRAC_BITS = 16;
  // Fraction bits of the internal format
  localparam int unsigned IFB       = 28;

  localparam logic [28:0] ONE_I        = 29'(64'd1 << IFB);
  localparam logic [27:0] LN2_I        = 28'd186065280;
  localparam logic [26:0] INV_SQRT_2PI = 27'd107090253;
  localparam logic [25:0] B0_I         = 26'd62180899;
  localparam logic signed [31:0] B1_I  = 32'sd85733327;
  localparam logic signed [31:0] B2_I  = -32'sd95714361;
  localparam logic signed [31:0] B3_I  = 32'sd478211842;
  localparam logic signed [31:0] B4_I  = -32'sd488889679;
  localparam logic signed [31:0] B5_I  = 32'sd357092823;

  localparam logic [16:0] AREA_ONE = 17'd65536;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MEAN,
    CFG_INV_DEV,
    CFG_PEAK
  } cfg_idx_t;

  // Saturation flags that ride alongside the datapath
  typedef struct packed {
    logic clip;
    logic neg;
  } side_t;

  // Signed a times unsigned t in internal format, truncated toward zero
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic [28:0] t);
    logic [31:0] mag;
    logic [60:0] prod;
    logic [31:0] p;
    mag  = a[31] ? 32'(-a) : a;
    prod = 61'(mag) * 61'(t);
    p    = prod[59:28];
    return a[31] ? -$signed(p) : $signed(p);
  endfunction

endpackage

@@ design/gpce_exp.sv @@
// ----------------------------------------------------------------------------
// gpce_exp: pipelined exp(-z*z/2)
// Squares |z|, splits the exponent into k*ln2 + r, evaluates exp(-r) by a
// ten-term Taylor series (two stages per term) and shifts right by k.
// ----------------------------------------------------------------------------
module gpce_exp import gpce_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] zi,
  output logic [28:0] e
);

  localparam logic [34:0] EXP_LIMIT = 35'(64'd40 * 64'(LN2_I));
  localparam logic [16:0] K_RECIP   = 17'((64'd1 << 44) / 64'(LN2_I));

  logic [63:0] sq;
  logic [34:0] u;
  logic [29:0] kp;
  logic [33:0] kl;
  logic [33:0] r0;

  logic [32:0] u1_r, u2_r;
  logic        ez1_r, ez2_r, ez3_r;
  logic [5:0]  k2_r, k3_r;
  logic [28:0] r3_r;

  // Taylor stage outputs: index 0 comes from the range reduction
  logic [28:0]        tm_r [0:10];
  logic signed [30:0] sm_r [0:10];
  logic [27:0]        rr_r [0:10];
  logic [5:0]         kk_r [0:10];
  logic               zz_r [0:10];

  logic [27:0]        pa_r [1:10];
  logic signed [30:0] sa_r [1:10];
  logic [27:0]        ra_r [1:10];
  logic [5:0]         ka_r [1:10];
  logic               za_r [1:10];

  logic [29:0] sp;
  logic [28:0] e_r;

  assign sq = 64'(zi) * 64'(zi);
  assign u  = sq[63:29];
  assign kp = 30'(u1_r[32:20]) * 30'(K_RECIP);
  assign kl = 34'(k2_r) * 34'(LN2_I);
  assign r0 = 34'(u2_r) - kl;

  // Square, estimate k, remainder, correct k
  always_ff @(posedge clk) begin
    if (adv) begin
      u1_r  <= u[32:0];
      ez1_r <= (u >= EXP_LIMIT);
      u2_r  <= u1_r;
      ez2_r <= ez1_r;
      k2_r  <= kp[29:24];
      r3_r  <= r0[28:0];
      k3_r  <= k2_r;
      ez3_r <= ez2_r;
      tm_r[0] <= ONE_I;
      sm_r[0] <= 31'(ONE_I);
      zz_r[0] <= ez3_r;
      if (r3_r >= 29'(LN2_I)) begin
        rr_r[0] <= 28'(r3_r - 29'(LN2_I));
        kk_r[0] <= k3_r + 6'd1;
      end else begin
        rr_r[0] <= r3_r[27:0];
        kk_r[0] <= k3_r;
      end
    end
  end

  // One Taylor term per pair of stages
  for (genvar n = 1; n <= 10; n++) begin : g_term
    localparam logic [32:0] M_N = 33'(((64'd1 << 32) + 64'(n) - 64'd1) / 64'(n));
    logic [55:0] pr;
    logic [60:0] qr;
    assign pr = 56'(tm_r[n-1]) * 56'(rr_r[n-1]);
    assign qr = 61'(pa_r[n]) * 61'(M_N);
    always_ff @(posedge clk) begin
      if (adv) begin
        pa_r[n] <= pr[55:28];
        sa_r[n] <= sm_r[n-1];
        ra_r[n] <= rr_r[n-1];
        ka_r[n] <= kk_r[n-1];
        za_r[n] <= zz_r[n-1];
        tm_r[n] <= qr[60:32];
        if ((n % 2) == 1) begin
          sm_r[n] <= sa_r[n] - $signed(31'(qr[60:32]));
        end else begin
          sm_r[n] <= sa_r[n] + $signed(31'(qr[60:32]));
        end
        rr_r[n] <= ra_r[n];
        kk_r[n] <= ka_r[n];
        zz_r[n] <= za_r[n];
      end
    end
  end

  // Clamp and scale by 2^-k
  assign sp = sm_r[10][30] ? 30'd0 : sm_r[10][29:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r <= zz_r[10] ? 29'd0 : 29'(sp >> kk_r[10]);
    end
  end

  assign e = e_r;

endmodule

@@ design/gpce_poly.sv @@
// ----------------------------------------------------------------------------
// gpce_poly: tail polynomial in t = 1/(1 + b0*|z|)
// Forms the denominator, divides 2^56 by it one quotient bit per stage,
// then runs the five Horner steps one multiply per stage.
// ----------------------------------------------------------------------------
module gpce_poly import gpce_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic [31:0]        zi,
  output logic signed [31:0] acc
);

  localparam int unsigned QB = 29;

  logic [57:0] bz;
  logic [30:0] den0_r;

  logic [30:0] rem_r [0:QB-1];
  logic [28:0] q_r   [0:QB-1];
  logic [30:0] dn_r  [0:QB-1];

  logic signed [31:0] hacc_r [1:5];
  logic [28:0]        ht_r   [1:4];

  assign bz = 58'(zi) * 58'(B0_I);

  // Denominator 1 + b0*|z|
  always_ff @(posedge clk) begin
    if (adv) begin
      den0_r <= 31'(ONE_I) + 31'(bz[57:28]);
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [30:0] rin;
    logic [28:0] qin;
    logic [30:0] din;
    logic [31:0] tr;
    logic        ge;
    if (j == 0) begin : g_first
      assign rin = 31'(64'd1 << (2 * IFB - QB));
      assign qin = '0;
      assign din = den0_r;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
      assign din = dn_r[j-1];
    end
    assign tr = {rin, 1'b0};
    assign ge = (tr >= {1'b0, din});
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j] <= ge ? 31'(tr - {1'b0, din}) : tr[30:0];
        q_r[j]   <= {qin[27:0], ge};
        dn_r[j]  <= din;
      end
    end
  end

  // Horner steps
  always_ff @(posedge clk) begin
    if (adv) begin
      hacc_r[1] <= B4_I + mulq(B5_I, q_r[QB-1]);
      ht_r[1]   <= q_r[QB-1];
      hacc_r[2] <= B3_I + mulq(hacc_r[1], ht_r[1]);
      ht_r[2]   <= ht_r[1];
      hacc_r[3] <= B2_I + mulq(hacc_r[2], ht_r[2]);
      ht_r[3]   <= ht_r[2];
      hacc_r[4] <= B1_I + mulq(hacc_r[3], ht_r[3]);
      ht_r[4]   <= ht_r[3];
      hacc_r[5] <= mulq(hacc_r[4], ht_r[4]);
    end
  end

  assign acc = hacc_r[5];

endmodule

@@ design/gaussian_pdf_cdf_eval_core.sv @@
// ----------------------------------------------------------------------------
// gaussian_pdf_cdf_eval_core: normal density and cumulative area evaluator
// Standardizes x against the configured mean and deviation and returns the
// density, the five-term polynomial cumulative area and a saturation flag.
// ----------------------------------------------------------------------------
// The core accepts one request per clock and returns the results in the
// order the requests were accepted. The latency is set by the 29-stage
// reciprocal divider plus the five-stage Horner chain that produces the tail
// polynomial; the exponential runs alongside it. When the result at the
// output is not taken, the whole pipeline holds and in_ready drops. The
// configuration port is always ready; write it only while no request is in
// flight.
module gaussian_pdf_cdf_eval_core import gpce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_density,
  output logic [16:0] out_area,
  output logic        out_z_clipped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned DEPTH  = 40;
  localparam int unsigned SD_LEN = 36;
  localparam int unsigned DL_LEN = 9;
  localparam int unsigned ZSH    = IFB - FRAC_BITS;

  typedef struct packed {
    logic [31:0] density;
    logic [26:0] phi;
  } dens_t;

  logic              adv;
  logic [DEPTH-1:0]  vld_r;

  logic [31:0] mean_r, inv_dev_r, peak_r;

  logic [32:0] dx;
  logic [31:0] mag, mag_r;
  logic        neg1_r, neg2_r;
  logic [63:0] prod, prod_r;
  logic [64+ZSH-1:0] widez;
  logic [31:0] zi_r;
  side_t       side3_r;
  side_t       sd_r [0:SD_LEN-1];

  logic [28:0]        e;
  logic signed [31:0] acc;
  logic [63:0]        dp;
  logic [55:0]        pp;
  dens_t              ph_r;
  dens_t              dl_r [0:DL_LEN-1];
  logic signed [31:0] tail_r;
  logic [31:0]        dens_t_r;

  logic [28:0] tc;
  logic [28:0] area_i;
  logic [29:0] area_rnd;

  logic [31:0] density_r;
  logic [16:0] area_r;
  logic        clip_r;

  assign adv       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r    <= 32'd0;
      inv_dev_r <= 32'd65536;
      peak_r    <= 32'd26145;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MEAN:    mean_r    <= cfg_data;
        CFG_INV_DEV: inv_dev_r <= cfg_data;
        CFG_PEAK:    peak_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // Front end: distance, scale, clip test
  assign dx    = {in_x[31], in_x} - {mean_r[31], mean_r};
  assign mag   = dx[32] ? 32'(-dx) : dx[31:0];
  assign prod  = 64'(mag_r) * 64'(inv_dev_r);
  assign widez = {prod_r, {ZSH{1'b0}}};

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r        <= mag;
      neg1_r       <= dx[32];
      prod_r       <= prod;
      neg2_r       <= neg1_r;
      zi_r         <= widez[FRAC_BITS +: 32];
      side3_r.clip <= |prod_r[63:2*FRAC_BITS+4];
      side3_r.neg  <= neg2_r;
    end
  end

  gpce_exp u_exp (
    .clk (clk),
    .adv (adv),
    .zi  (zi_r),
    .e   (e)
  );

  gpce_poly u_poly (
    .clk (clk),
    .adv (adv),
    .zi  (zi_r),
    .acc (acc)
  );

  // Delay saturation flags to the output stage
  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side3_r;
      for (int i = 1; i < SD_LEN; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  // Density and standard density, then hold them for the polynomial
  assign dp = 64'(peak_r) * 64'(e);
  assign pp = 56'(INV_SQRT_2PI) * 56'(e);

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r.density <= dp[59:28];
      ph_r.phi     <= pp[54:28];
      dl_r[0]      <= ph_r;
      for (int i = 1; i < DL_LEN; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
      tail_r   <= mulq(acc, 29'(dl_r[DL_LEN-1].phi));
      dens_t_r <= dl_r[DL_LEN-1].density;
    end
  end

  // Clamp tail, apply symmetry, round to Q1.16
  always_comb begin
    if (tail_r[31]) begin
      tc = 29'd0;
    end else if (tail_r > $signed(32'(ONE_I))) begin
      tc = ONE_I;
    end else begin
      tc = tail_r[28:0];
    end
    area_i   = sd_r[SD_LEN-1].neg ? tc : ONE_I - tc;
    area_rnd = 30'(area_i) + 30'd2048;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip_r <= sd_r[SD_LEN-1].clip;
      if (sd_r[SD_LEN-1].clip) begin
        density_r <= 32'd0;
        area_r    <= sd_r[SD_LEN-1].neg ? 17'd0 : AREA_ONE;
      end else begin
        density_r <= dens_t_r;
        area_r    <= area_rnd[28:12];
      end
    end
  end

  assign out_valid     = vld_r[DEPTH-1];
  assign out_density   = density_r;
  assign out_area      = area_r;
  assign out_z_clipped = clip_r;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r))
    else $error("pipeline moved while output stalled");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted request not tracked");
  a_clip_density: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_z_clipped |-> out_density == 32'd0)
    else $error("clipped result with nonzero density");
  a_area_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_area <= AREA_ONE)
    else $error("area above one");
`endif

endmodule

@@ test/gaussian_pdf_cdf_eval_core_test.sv @@
// ----------------------------------------------------------------------------
// gaussian_pdf_cdf_eval_core_test: self-checking bench for the Gaussian core
// Drives abscissas under several register settings with random idling and
// back-pressure, predicts density, area and the clip flag for each accepted
// request and compares every result in order against that prediction.
// ----------------------------------------------------------------------------
module gaussian_pdf_cdf_eval_core_test;
  import gpce_pkg::*;

  typedef struct packed {
    logic [31:0] density;
    logic [16:0] area;
    logic        clipped;
  } gauss_res_t;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 250;

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [31:0] in_x, out_density, cfg_data;
  logic [16:0] out_area;
  logic        out_z_clipped;
  logic [1:0]  cfg_index;

  // predictor copy of the registers
  logic [31:0] mean_r, inv_dev_r, peak_r;

  logic [31:0] x_queue[$];
  gauss_res_t  pending_res[$];
  int          mismatches;
  int          cycles;
  bit          quiet;
  bit          in_taken;
  int          send_gap, recv_gap, hold_left;
  int          hold_requests, hold_seen;

  gaussian_pdf_cdf_eval_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_x(in_x),
    .out_valid(out_valid), .out_ready(out_ready), .out_density(out_density),
    .out_area(out_area), .out_z_clipped(out_z_clipped),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // signed times unsigned in internal format, truncated toward zero
  function automatic longint fx_mul(longint a, bit [63:0] b);
    bit [63:0] mag;
    bit [63:0] p;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    p = (mag * b) >> IFB;
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  // density, cumulative area and clip flag for one abscissa
  function automatic gauss_res_t gauss_eval(logic [31:0] x);
    gauss_res_t res;
    longint     d, sum, acc, tail;
    bit [63:0]  mag, prod, zi, u, k, r, term, e, phi, den, t, area_i;
    bit         neg;
    d = longint'($signed(x)) - longint'($signed(mean_r));
    neg = d < 0;
    mag = neg ? 64'(-d) : 64'(d);
    prod = mag * 64'(inv_dev_r);
    if (prod >= (64'd16 << (2 * FRAC_BITS))) begin
      res.density = '0;
      res.area = neg ? 17'd0 : AREA_ONE;
      res.clipped = 1'b1;
      return res;
    end
    zi = (prod << (IFB - FRAC_BITS)) >> FRAC_BITS;
    u = (zi * zi) >> (IFB + 1);
    // exp(-u) by range reduction and a truncated Taylor series
    k = u / 64'(LN2_I);
    r = u - k * 64'(LN2_I);
    term = 64'd1 << IFB;
    sum = longint'(term);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * r) >> IFB) / n;
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    e = (k >= 40) ? 64'd0 : (64'(sum) >> k);
    res.density = 32'((64'(peak_r) * e) >> IFB);
    phi = (64'(INV_SQRT_2PI) * e) >> IFB;
    den = (64'd1 << IFB) + ((64'(B0_I) * zi) >> IFB);
    t = (64'd1 << (2 * IFB)) / den;
    acc = longint'(B5_I);
    acc = longint'(B4_I) + fx_mul(acc, t);
    acc = longint'(B3_I) + fx_mul(acc, t);
    acc = longint'(B2_I) + fx_mul(acc, t);
    acc = longint'(B1_I) + fx_mul(acc, t);
    acc = fx_mul(acc, t);
    tail = fx_mul(acc, phi);
    if (tail < 0) tail = 0;
    if (tail > (longint'(1) << IFB)) tail = longint'(1) << IFB;
    area_i = neg ? 64'(tail) : (64'd1 << IFB) - 64'(tail);
    res.area = 17'((area_i + 64'd2048) >> 12);
    res.clipped = 1'b0;
    return res;
  endfunction

  // sender: hold an unaccepted request, otherwise idle or present the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && x_queue.size() > 0 && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (x_queue.size() > 0) begin
        in_x <= x_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold on request, else random stall bursts
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk) begin
    gauss_res_t want;
    cycles <= cycles + 1;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) pending_res.push_back(gauss_eval(in_x));
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected result: density %h area %h clip %b",
                   out_density, out_area, out_z_clipped);
      end else begin
        want = pending_res.pop_front();
        if (want.density !== out_density || want.area !== out_area ||
            want.clipped !== out_z_clipped) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp density %h area %h clip %b, got %h %h %b",
                     want.density, want.area, want.clipped,
                     out_density, out_area, out_z_clipped);
        end
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("gaussian_pdf_cdf_eval_core test failed");
      $finish;
    end
  end

  // wait until no request is queued, offered or in flight
  task automatic drain();
    do @(negedge clk);
    while (x_queue.size() > 0 || in_valid || pending_res.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_MEAN:    mean_r = val;
      CFG_INV_DEV: inv_dev_r = val;
      CFG_PEAK:    peak_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dist(logic [31:0] m, logic [31:0] iv, logic [31:0] pk);
    write_reg(CFG_MEAN, m);
    write_reg(CFG_INV_DEV, iv);
    write_reg(CFG_PEAK, pk);
  endtask

  // mostly points inside the clip range around the mean, some anywhere
  task automatic queue_random(int count);
    longint span, off;
    for (int i = 0; i < count; i++) begin
      span = (longint'(1) << 36) / longint'(inv_dev_r);
      span = span + span / 8;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      if ($urandom_range(0, 4) == 0) begin
        x_queue.push_back($urandom);
      end else begin
        off = longint'({$urandom, $urandom}) % (span + 1);
        if (off < 0) off = -off;
        if ($urandom_range(0, 1)) off = -off;
        x_queue.push_back(32'(longint'($signed(mean_r)) + off));
      end
    end
  endtask

  initial begin
    logic [31:0] iv;
    rst_n = 0;
    in_valid = 0;
    in_x = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = CFG_MEAN;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    quiet = 0;
    in_taken = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    hold_requests = 0;
    hold_seen = 0;
    mean_r = '0;
    inv_dev_r = 32'd65536;
    peak_r = 32'd26145;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, zero z, both sides of the clip edge
    x_queue = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF,
                32'h0010_0000, 32'hFFF0_0000, 32'h000F_FFFF, 32'hFFF0_0001,
                32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'hFFFD_8000,
                32'h0000_4000, 32'h0004_0000, 32'hFFFA_0000};
    drain();
    // widest deviation, full peak; unused index must be ignored
    set_dist(32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE, $urandom);
    x_queue = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0001};
    queue_random(40);
    drain();
    // narrowest deviation, zero peak
    set_dist(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    x_queue = '{32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000};
    queue_random(40);
    drain();

    // random settings; one phase with a long receiver hold
    for (int ph = 0; ph < 6; ph++) begin
      iv = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(4096, 600000);
      if (iv == 0) iv = 1;
      set_dist($urandom, iv, $urandom);
      if (ph == 5) quiet = 1;
      if (ph == 1) hold_requests = hold_requests + 1;
      queue_random(130);
      drain();
    end

    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("gaussian_pdf_cdf_eval_core test passed");
    end else begin
      $display("gaussian_pdf_cdf_eval_core test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/gpce_pkg.sv
design/gpce_exp.sv
design/gpce_poly.sv
design/gaussian_pdf_cdf_eval_core.sv
test/gaussian_pdf_cdf_eval_core_test.sv
